FILE: design/ajb_pkg.sv
// ----------------------------------------------------------------------------
// ajb_pkg
// Shared types and constants for the audio jitter buffer.
// ----------------------------------------------------------------------------
package ajb_pkg;

  localparam int SZW = 13;              // size / slot width
  localparam int PW  = 64;              // stream position width
  localparam int DW  = 8;               // audio byte width
  localparam int STW = 4;               // status width
  localparam int STORE_BYTES_DEF = 4096;
  localparam logic [SZW-1:0] BSIZE_RST = 13'd4096;

  localparam logic [1:0] ADDR_BSIZE = 2'd0;

  localparam logic [1:0] REQ_HDR  = 2'd0;
  localparam logic [1:0] REQ_BYTE = 2'd1;
  localparam logic [1:0] REQ_PLAY = 2'd2;

  localparam logic [STW-1:0] ST_HDR_OK      = 4'd0;
  localparam logic [STW-1:0] ST_NEW_SESSION = 4'd1;
  localparam logic [STW-1:0] ST_STALE       = 4'd2;
  localparam logic [STW-1:0] ST_TOO_OLD     = 4'd3;
  localparam logic [STW-1:0] ST_BAD_LEN     = 4'd4;
  localparam logic [STW-1:0] ST_WRITTEN     = 4'd5;
  localparam logic [STW-1:0] ST_IGNORED     = 4'd6;
  localparam logic [STW-1:0] ST_PLAY_OK     = 4'd7;
  localparam logic [STW-1:0] ST_NO_PLAY     = 4'd8;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DECODE, S_DIVU, S_EVAL, S_DIVS,
    S_CLEAR, S_FINISH, S_PLAYRD, S_RESP
  } state_t;

  typedef struct packed {
    logic latch;
    logic decode;
    logic div_go;
    logic div_sel;     // 0: usable size, 1: slot of first byte
    logic usable_ld;
    logic eval;
    logic apply;
    logic clr_step;
    logic finish;
    logic play_cap;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       bad_len;
    logic       new_sess;
    logic       play_ok;
    logic       reject;
    logic       div_busy;
    logic       clr_busy;
  } stat_t;

endpackage

FILE: design/audio_jitter_buffer.sv
// ----------------------------------------------------------------------------
// audio_jitter_buffer
// Circular audio playout buffer with session handling and gap clearing.
// ----------------------------------------------------------------------------
// Sequence: payload, refused-play, bad-length and unknown items pass DECODE then RESP
// after accept, a play that reads the store DECODE, PLAYRD, RESP; the next item is taken in the cycle after RESP.
// Headers that pass the session checks add a remainder run (two on a new session)
// and a clear of each gap byte, or a sweep of the whole store for a full wipe.
// Reset: a clearing pass over all STORE_BYTES bytes wipes the store; busy stays
// high meanwhile. The receiver cannot stall; out_valid is a one-cycle strobe.
module audio_jitter_buffer import ajb_pkg::*; #(
  parameter int STORE_BYTES = STORE_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic [1:0]     in_req_type,
  input  logic [PW-1:0]  in_session_id,
  input  logic [PW-1:0]  in_first_byte,
  input  logic [SZW-1:0] in_payload_len,
  input  logic [DW-1:0]  in_data_byte,
  output logic           out_valid,
  output logic [STW-1:0] out_status,
  output logic [DW-1:0]  out_play_data,
  output logic           out_playing,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [1:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  cmd_t           cmd;
  stat_t          stat;
  logic [SZW-1:0] bsize_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsize_r <= BSIZE_RST;
    end else if (psel && penable && pwrite && paddr == ADDR_BSIZE) begin
      bsize_r <= pwdata[SZW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = 32'(bsize_r);

  ajb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  ajb_dp #(.STORE_BYTES(STORE_BYTES)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .bsize          (bsize_r),
    .in_req_type    (in_req_type),
    .in_session_id  (in_session_id),
    .in_first_byte  (in_first_byte),
    .in_payload_len (in_payload_len),
    .in_data_byte   (in_data_byte),
    .out_status     (out_status),
    .out_play_data  (out_play_data),
    .out_playing    (out_playing)
  );

endmodule

FILE: design/ajb_ram.sv
// ----------------------------------------------------------------------------
// ajb_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ajb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/ajb_mod.sv
// ----------------------------------------------------------------------------
// ajb_mod
// Bit-serial remainder unit: 64-bit dividend by 13-bit divisor, one bit/cycle.
// ----------------------------------------------------------------------------
module ajb_mod import ajb_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [PW-1:0]  dividend,
  input  logic [SZW-1:0] divisor,
  output logic           busy,
  output logic [SZW-1:0] rem
);

  logic [6:0]     cnt_r;
  logic [PW-1:0]  dvd_r;
  logic [SZW-1:0] div_r;
  logic [SZW-1:0] rem_r;
  logic [SZW:0]   trial;

  assign trial = {rem_r, dvd_r[PW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= 7'(PW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= dvd_r << 1;
      if (trial >= {1'b0, div_r}) begin
        rem_r <= SZW'(trial - {1'b0, div_r});
      end else begin
        rem_r <= trial[SZW-1:0];
      end
    end
  end

  assign busy = (cnt_r != '0);
  assign rem  = rem_r;

endmodule

FILE: design/ajb_dp.sv
// ----------------------------------------------------------------------------
// ajb_dp
// Datapath: session registers, slot pointers, clear sweep and audio store.
// ----------------------------------------------------------------------------
module ajb_dp import ajb_pkg::*; #(
  parameter int STORE_BYTES = STORE_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cmd_t           cmd,
  output stat_t          stat,
  input  logic [SZW-1:0] bsize,
  input  logic [1:0]     in_req_type,
  input  logic [PW-1:0]  in_session_id,
  input  logic [PW-1:0]  in_first_byte,
  input  logic [SZW-1:0] in_payload_len,
  input  logic [DW-1:0]  in_data_byte,
  output logic [STW-1:0] out_status,
  output logic [DW-1:0]  out_play_data,
  output logic           out_playing
);

  localparam int AW = $clog2(STORE_BYTES);

  logic [1:0]     req_r;
  logic [PW-1:0]  sid_r, first_r;
  logic [SZW-1:0] len_r;
  logic [DW-1:0]  byte_r;

  logic [PW-1:0]  cur_r, base_r, ppos_r, wpos_r;
  logic           open_r, playing_r, acc_r;
  logic [SZW-1:0] psize_r, usable_r, off_r;
  logic [SZW-1:0] pslot_r, wslot_r, kslot_r;
  logic           clr_full_r;
  logic [AW-1:0]  clr_addr_r;
  logic [SZW-1:0] clr_cnt_r;
  logic [STW-1:0] status_r;
  logic [DW-1:0]  data_r;

  logic [SZW-1:0] eff;
  logic [SZW+1:0] thresh;
  logic [PW-1:0]  usable64, gap, nw;
  logic           byte_ok, play_ok, stale, too_old, div_busy;
  logic [SZW-1:0] div_rem, nslot, fslot;
  logic [SZW:0]   nsum;
  logic           ram_we;
  logic [AW-1:0]  ram_addr;
  logic [DW-1:0]  ram_wdata, ram_rdata;

  always_comb begin
    if (bsize == '0) begin
      eff = SZW'(1);
    end else if (32'(bsize) > STORE_BYTES) begin
      eff = SZW'(STORE_BYTES);
    end else begin
      eff = bsize;
    end
  end

  assign thresh   = (SZW+2)'(({2'b00, eff} * 3) >> 2);
  assign usable64 = PW'(usable_r);
  assign byte_ok  = acc_r && open_r && (off_r < psize_r);
  assign play_ok  = open_r && playing_r && (ppos_r < wpos_r) && (usable_r != '0);
  assign stale    = sid_r < cur_r;
  assign too_old  = (wpos_r >= usable64) && (first_r < wpos_r - usable64);
  assign gap      = first_r - wpos_r;
  assign nw       = first_r + PW'(psize_r);
  assign fslot    = div_rem;
  assign nsum     = {1'b0, fslot} + {1'b0, psize_r};
  assign nslot    = (nsum >= {1'b0, usable_r}) ? SZW'(nsum - {1'b0, usable_r})
                                               : nsum[SZW-1:0];

  assign stat.req      = req_r;
  assign stat.bad_len  = (len_r == '0) || (len_r > eff);
  assign stat.new_sess = !open_r || (sid_r > cur_r);
  assign stat.play_ok  = play_ok;
  assign stat.reject   = stale || too_old;
  assign stat.div_busy = div_busy;
  assign stat.clr_busy = clr_full_r || (clr_cnt_r != '0);

  ajb_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (cmd.div_sel ? first_r : PW'(eff)),
    .divisor  (cmd.div_sel ? usable_r : len_r),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r     <= 1'b0;
      playing_r  <= 1'b0;
      acc_r      <= 1'b0;
      clr_full_r <= 1'b1;
      clr_addr_r <= '0;
      clr_cnt_r  <= '0;
    end else begin
      if (cmd.decode && req_r == REQ_HDR) begin
        acc_r <= 1'b0;
        if (!stat.bad_len && stat.new_sess) begin
          open_r     <= 1'b1;
          playing_r  <= 1'b0;
          clr_full_r <= 1'b1;
          clr_addr_r <= '0;
        end
      end
      if (cmd.apply) begin
        acc_r <= 1'b1;
        if (first_r >= wpos_r && !clr_full_r) begin
          if (gap < usable64) begin
            clr_addr_r <= AW'(wslot_r);
            clr_cnt_r  <= gap[SZW-1:0];
          end else begin
            clr_full_r <= 1'b1;
            clr_addr_r <= '0;
          end
        end
      end
      if (cmd.clr_step) begin
        if (clr_full_r) begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(STORE_BYTES - 1)) begin
            clr_full_r <= 1'b0;
          end
        end else if (clr_cnt_r != '0) begin
          clr_cnt_r <= clr_cnt_r - SZW'(1);
          if (32'(clr_addr_r) + 1 == 32'(usable_r)) begin
            clr_addr_r <= '0;
          end else begin
            clr_addr_r <= clr_addr_r + AW'(1);
          end
        end
      end
      if (cmd.finish && first_r >= base_r && (first_r - base_r) >= PW'(thresh)) begin
        playing_r <= 1'b1;
      end
    end
  end

  // payload and positions
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r  <= in_req_type;
      sid_r  <= in_session_id;
      first_r <= in_first_byte;
      len_r  <= in_payload_len;
      byte_r <= in_data_byte;
      data_r <= '0;
    end
    if (cmd.decode) begin
      case (req_r)
        REQ_HDR: begin
          if (stat.bad_len) begin
            status_r <= ST_BAD_LEN;
          end else if (stat.new_sess) begin
            status_r <= ST_NEW_SESSION;
            cur_r    <= sid_r;
            base_r   <= first_r;
            ppos_r   <= first_r;
            wpos_r   <= first_r;
            psize_r  <= len_r;
          end else begin
            status_r <= ST_HDR_OK;
          end
        end
        REQ_BYTE: begin
          if (byte_ok) begin
            status_r <= ST_WRITTEN;
            off_r    <= off_r + SZW'(1);
            kslot_r  <= (kslot_r + SZW'(1) == usable_r) ? '0 : kslot_r + SZW'(1);
          end else begin
            status_r <= ST_IGNORED;
          end
        end
        REQ_PLAY: begin
          if (play_ok) begin
            status_r <= ST_PLAY_OK;
            ppos_r   <= ppos_r + PW'(1);
            pslot_r  <= (pslot_r + SZW'(1) == usable_r) ? '0 : pslot_r + SZW'(1);
          end else begin
            status_r <= ST_NO_PLAY;
          end
        end
        default: status_r <= ST_IGNORED;
      endcase
    end
    if (cmd.usable_ld) begin
      usable_r <= eff - div_rem;
    end
    if (cmd.eval) begin
      if (stale) begin
        status_r <= ST_STALE;
      end else if (too_old) begin
        status_r <= ST_TOO_OLD;
      end
    end
    if (cmd.apply) begin
      kslot_r <= fslot;
      off_r   <= '0;
      if (first_r >= wpos_r) begin
        wpos_r  <= nw;
        wslot_r <= nslot;
        if (nw >= usable64 && nw - usable64 > ppos_r) begin
          ppos_r  <= nw - usable64;
          pslot_r <= nslot;
        end else if (ppos_r == first_r) begin
          // play position sits on this packet (fresh session, or a drained buffer): resync its slot
          pslot_r <= fslot;
        end
      end
    end
    if (cmd.play_cap) begin
      data_r <= ram_rdata;
    end
  end

  always_comb begin
    ram_we    = cmd.clr_step || (cmd.decode && req_r == REQ_BYTE && byte_ok);
    ram_wdata = cmd.clr_step ? '0 : byte_r;
    if (cmd.clr_step) begin
      ram_addr = clr_addr_r;
    end else if (req_r == REQ_BYTE) begin
      ram_addr = AW'(kslot_r);
    end else begin
      ram_addr = AW'(pslot_r);
    end
  end

  ajb_ram #(.WIDTH(DW), .DEPTH(STORE_BYTES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_status    = status_r;
  assign out_play_data = data_r;
  assign out_playing   = playing_r;

endmodule

FILE: design/ajb_ctrl.sv
// ----------------------------------------------------------------------------
// ajb_ctrl
// Controller: sequences decode, remainder runs, gap clearing and response.
// ----------------------------------------------------------------------------
module ajb_ctrl import ajb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  output logic  out_valid,
  output cmd_t  cmd,
  input  stat_t stat
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        if (stat.clr_busy) begin
          cmd.clr_step = 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = S_RESP;
        if (stat.req == REQ_HDR && !stat.bad_len) begin
          if (stat.new_sess) begin
            cmd.div_go = 1'b1;
            state_nxt  = S_DIVU;
          end else begin
            state_nxt = S_EVAL;
          end
        end else if (stat.req == REQ_PLAY && stat.play_ok) begin
          state_nxt = S_PLAYRD;
        end
      end
      S_DIVU: begin
        if (!stat.div_busy) begin
          cmd.usable_ld = 1'b1;
          state_nxt     = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.reject) begin
          state_nxt = S_CLEAR;
        end else begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = 1'b1;
          state_nxt   = S_DIVS;
        end
      end
      S_DIVS: begin
        if (!stat.div_busy) begin
          cmd.apply = 1'b1;
          state_nxt = S_CLEAR;
        end
      end
      S_CLEAR: begin
        if (stat.clr_busy) begin
          cmd.clr_step = 1'b1;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_RESP;
      end
      S_PLAYRD: begin
        cmd.play_cap = 1'b1;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);

endmodule
